// File: hdl/lzwd_pkg.sv
// Shared types and constants for the LZ window decompressor.
`timescale 1ns / 1ps

package lzwd_pkg;

   localparam int WIN_BITS     = 14;
   localparam int WIN_SIZE     = 1 << WIN_BITS;
   localparam int HEADER_BYTES = 4;
   localparam int DIST_W       = 14;
   localparam int RUN_W        = 9;
   localparam int MAX_RUN      = 258;
   localparam int MATCH_BIAS   = 3;

   localparam logic [1:0] HDR_LEFT_RESET = 2'(HEADER_BYTES - 1);

   localparam logic OP_DATA = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] ST_BYTE = 2'd0;
   localparam logic [1:0] ST_END  = 2'd1;
   localparam logic [1:0] ST_BUSY = 2'd2;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_CMD    = 3'd1,
      PH_DIST   = 3'd2,
      PH_LEN    = 3'd3,
      PH_LIT    = 3'd4,
      PH_COPY   = 3'd5,
      PH_DONE   = 3'd6
   } phase_type;

   typedef struct packed {
      logic                en;
      logic [WIN_BITS-1:0] addr;
      logic                known;
   } hist_rd_type;

   typedef struct packed {
      logic                en;
      logic [WIN_BITS-1:0] addr;
      logic [7:0]          data;
   } hist_wr_type;

   typedef struct packed {
      logic                has_res;
      logic                is_copy;
      logic                wr_en;
      logic [WIN_BITS-1:0] wr_addr;
      logic [7:0]          lit_byte;
      logic [1:0]          status;
      logic [RUN_W-1:0]    copy_left;
   } stage_type;

endpackage

// File: hdl/lz_window_decompressor.sv
// Top level of the byte-serial LZ77 decompressor with a 16K history window.
`timescale 1ns / 1ps

// The block takes one stream byte or copy tick per cycle while req_stall is low and
// returns at most one result per transaction, registered in the memory stage and
// then in the output register. Every transaction does at most one read and one
// write of the single window memory (one read port, one write port); the write of
// a copied byte is forwarded to a read of the same entry in the same cycle, so
// overlapping copies of any distance stream at one byte per cycle when not stalled.
// The window needs no clearing pass after reset: the write pointer and a wrap flag
// tell which entries have been written, and all others read as zero.

module lz_window_decompressor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic [8:0] rsp_copy_left
);

   localparam int POS_W = lzwd_pkg::WIN_BITS;
   localparam int RUN_W = lzwd_pkg::RUN_W;

   lzwd_pkg::phase_type phase_ff, phase_in;
   logic [1:0]          hdr_left_ff, hdr_left_in;
   logic [POS_W-1:0]    wr_pos_ff, wr_pos_in;
   logic [POS_W-1:0]    rd_pos_ff, rd_pos_in;
   logic [RUN_W-1:0]    run_left_ff, run_left_in;
   logic [7:0]          cmd_hold_ff, cmd_hold_in;
   logic                wrapped_ff, wrapped_in;

   logic                s1_valid_ff;
   lzwd_pkg::stage_type s1_ff, s1_in;

   logic                out_valid_ff;
   logic [7:0]          out_byte_ff;
   logic [1:0]          out_status_ff;
   logic [RUN_W-1:0]    out_left_ff;

   lzwd_pkg::hist_rd_type hist_rd;
   lzwd_pkg::hist_wr_type hist_wr;
   logic [7:0]            hist_data;
   logic [7:0]            s1_byte;

   logic                accept;
   logic                s1_go;
   logic                is_tick;
   logic                copy_now;
   logic [lzwd_pkg::DIST_W-1:0] distm1;

   assign accept   = req_valid && !req_stall;
   assign s1_go    = s1_valid_ff && (!s1_ff.has_res || !out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;
   assign is_tick  = (req_op == lzwd_pkg::OP_TICK);
   assign copy_now = is_tick && (phase_ff == lzwd_pkg::PH_COPY) && (run_left_ff != '0);

   assign distm1 = cmd_hold_ff[1] ? {cmd_hold_ff[7:2], req_in_byte}
                                  : lzwd_pkg::DIST_W'({cmd_hold_ff[4:2], req_in_byte});

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (is_tick) begin
            if (copy_now && (run_left_ff == RUN_W'(1))) begin
               phase_in = lzwd_pkg::PH_CMD;
            end
         end else begin
            case (phase_ff)
               lzwd_pkg::PH_HEADER: begin
                  if (hdr_left_ff == 2'd0) begin
                     phase_in = lzwd_pkg::PH_CMD;
                  end
               end
               lzwd_pkg::PH_CMD: begin
                  if (req_in_byte == 8'd0) begin
                     phase_in = lzwd_pkg::PH_DONE;
                  end else if (!req_in_byte[0]) begin
                     phase_in = lzwd_pkg::PH_LIT;
                  end else begin
                     phase_in = lzwd_pkg::PH_DIST;
                  end
               end
               lzwd_pkg::PH_DIST: begin
                  phase_in = cmd_hold_ff[1] ? lzwd_pkg::PH_LEN : lzwd_pkg::PH_COPY;
               end
               lzwd_pkg::PH_LEN: begin
                  phase_in = lzwd_pkg::PH_COPY;
               end
               lzwd_pkg::PH_LIT: begin
                  if (run_left_ff == RUN_W'(1)) begin
                     phase_in = lzwd_pkg::PH_CMD;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // Counters, pointers and the transaction handed to the memory stage.
   always_comb begin
      hdr_left_in = hdr_left_ff;
      wr_pos_in   = wr_pos_ff;
      rd_pos_in   = rd_pos_ff;
      run_left_in = run_left_ff;
      cmd_hold_in = cmd_hold_ff;
      wrapped_in  = wrapped_ff;
      s1_in       = '0;
      s1_in.wr_addr = wr_pos_ff;

      hist_rd.en    = accept && copy_now;
      hist_rd.addr  = rd_pos_ff;
      hist_rd.known = wrapped_ff || (rd_pos_ff < wr_pos_ff);

      if (accept) begin
         if (is_tick) begin
            if (copy_now) begin
               s1_in.has_res   = 1'b1;
               s1_in.is_copy   = 1'b1;
               s1_in.wr_en     = 1'b1;
               s1_in.status    = lzwd_pkg::ST_BYTE;
               s1_in.copy_left = run_left_ff - RUN_W'(1);
               run_left_in     = run_left_ff - RUN_W'(1);
               rd_pos_in       = rd_pos_ff + POS_W'(1);
               wr_pos_in       = wr_pos_ff + POS_W'(1);
               if (wr_pos_ff == '1) begin
                  wrapped_in = 1'b1;
               end
            end
         end else begin
            case (phase_ff)
               lzwd_pkg::PH_HEADER: begin
                  if (hdr_left_ff != 2'd0) begin
                     hdr_left_in = hdr_left_ff - 2'd1;
                  end
               end
               lzwd_pkg::PH_CMD: begin
                  if (req_in_byte == 8'd0) begin
                     s1_in.has_res = 1'b1;
                     s1_in.status  = lzwd_pkg::ST_END;
                  end else if (!req_in_byte[0]) begin
                     run_left_in = RUN_W'(req_in_byte[7:1]);
                  end else begin
                     cmd_hold_in = req_in_byte;
                  end
               end
               lzwd_pkg::PH_DIST: begin
                  rd_pos_in = wr_pos_ff - POS_W'(distm1) - POS_W'(1);
                  if (!cmd_hold_ff[1]) begin
                     run_left_in = RUN_W'(cmd_hold_ff[7:5]) + RUN_W'(lzwd_pkg::MATCH_BIAS);
                  end
               end
               lzwd_pkg::PH_LEN: begin
                  run_left_in = RUN_W'(req_in_byte) + RUN_W'(lzwd_pkg::MATCH_BIAS);
               end
               lzwd_pkg::PH_LIT: begin
                  s1_in.has_res  = 1'b1;
                  s1_in.wr_en    = 1'b1;
                  s1_in.lit_byte = req_in_byte;
                  s1_in.status   = lzwd_pkg::ST_BYTE;
                  run_left_in    = run_left_ff - RUN_W'(1);
                  wr_pos_in      = wr_pos_ff + POS_W'(1);
                  if (wr_pos_ff == '1) begin
                     wrapped_in = 1'b1;
                  end
               end
               lzwd_pkg::PH_COPY: begin
                  // The byte is dropped; the pending copy stays as it is.
                  s1_in.has_res   = 1'b1;
                  s1_in.status    = lzwd_pkg::ST_BUSY;
                  s1_in.copy_left = run_left_ff;
               end
               default: begin
                  s1_in.has_res = 1'b1;
                  s1_in.status  = lzwd_pkg::ST_END;
               end
            endcase
         end
      end
   end

   assign s1_byte = s1_ff.is_copy ? hist_data : s1_ff.lit_byte;

   always_comb begin
      hist_wr.en   = s1_go && s1_ff.wr_en;
      hist_wr.addr = s1_ff.wr_addr;
      hist_wr.data = s1_byte;
   end

   lzwd_history u_history (
      .clock   (clock),
      .rd      (hist_rd),
      .wr      (hist_wr),
      .rd_data (hist_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= (lzwd_pkg::HEADER_BYTES == 0) ? lzwd_pkg::PH_CMD : lzwd_pkg::PH_HEADER;
         hdr_left_ff <= lzwd_pkg::HDR_LEFT_RESET;
         wr_pos_ff   <= '0;
         rd_pos_ff   <= '0;
         run_left_ff <= '0;
         cmd_hold_ff <= '0;
         wrapped_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         hdr_left_ff <= hdr_left_in;
         wr_pos_ff   <= wr_pos_in;
         rd_pos_ff   <= rd_pos_in;
         run_left_ff <= run_left_in;
         cmd_hold_ff <= cmd_hold_in;
         wrapped_ff  <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go && s1_ff.has_res) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_go && s1_ff.has_res) begin
         out_byte_ff   <= s1_byte;
         out_status_ff <= s1_ff.status;
         out_left_ff   <= s1_ff.copy_left;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_copy_left = out_left_ff;

endmodule

// File: hdl/lzwd_history.sv
// History window memory with one read and one write port and write-to-read forwarding.
`timescale 1ns / 1ps

module lzwd_history (
   input  logic                   clock,
   input  lzwd_pkg::hist_rd_type  rd,
   input  lzwd_pkg::hist_wr_type  wr,
   output logic [7:0]             rd_data
);

   logic [7:0] mem_ff [lzwd_pkg::WIN_SIZE];
   logic [7:0] rdata_ff;
   logic [7:0] fwd_data_ff;
   logic       fwd_hit_ff;
   logic       known_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rdata_ff <= mem_ff[rd.addr];
      end
   end

   // A write landing on the entry being read in the same cycle is not yet in
   // the array, so its data is captured alongside the read.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         fwd_hit_ff  <= wr.en && (wr.addr == rd.addr);
         fwd_data_ff <= wr.data;
         known_ff    <= rd.known;
      end
   end

   // Entries never written since reset read as zero.
   assign rd_data = fwd_hit_ff ? fwd_data_ff : (known_ff ? rdata_ff : 8'd0);

endmodule

// File: hdl/lzwd_checker.sv
// Port-level checks for the LZ window decompressor and their binding.
`timescale 1ns / 1ps

module lzwd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_status,
   input logic [8:0] rsp_copy_left
);

   // A result held back by the receiver stays unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_status) && $stable(rsp_copy_left))
      else $error("result changed while stalled");

   // Only byte results carry data.
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != lzwd_pkg::ST_BYTE) |-> rsp_out_byte == 8'd0)
      else $error("non-byte result carries data");

   // End of stream never reports a pending copy.
   a_end_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == lzwd_pkg::ST_END) |-> rsp_copy_left == 9'd0)
      else $error("end of stream with copy pending");

   // A pending copy is never longer than the longest match.
   a_left_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_copy_left <= 9'(lzwd_pkg::MAX_RUN))
      else $error("copy count out of range");

   // No result is shown in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind lz_window_decompressor lzwd_checker u_lzwd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_status    (rsp_status),
   .rsp_copy_left (rsp_copy_left)
);
